FILE: hdl/tpsd_pkg.sv
package tpsd_pkg;

  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 32;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CfgRleMode    = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgPixelBits  = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgPixelTotal = 8'd2;

  localparam logic [7:0]          BitsReset  = 8'd24;
  localparam logic [CfgDataW-1:0] TotalReset = 32'd1;

  localparam logic [7:0] Bits16 = 8'd16;
  localparam logic [7:0] Bits24 = 8'd24;
  localparam logic [7:0] Bits32 = 8'd32;

  localparam logic [7:0] RunBias = 8'd127;

  localparam logic StatusOk       = 1'b0;
  localparam logic StatusBadDepth = 1'b1;

  typedef struct packed {
    logic       rle_mode;
    logic [7:0] pixel_bits;
  } tpsd_cfg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       has_alpha;
    logic [7:0] repeat_count;
    logic       last_of_image;
    logic       status;
  } tpsd_res_t;

endpackage

FILE: hdl/tpsd_core.sv
module tpsd_core import tpsd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tpsd_cfg_t           cfg_i,
  input  logic                clear_i,
  input  logic [CfgDataW-1:0] total_i,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  output logic                res_valid_o,
  output tpsd_res_t           res_o
);

  typedef enum logic [1:0] {
    Depth16,
    Depth24,
    Depth32,
    DepthBad
  } depth_e;

  depth_e              depth;
  logic [1:0]          last_phase;
  logic                done;
  logic                header;
  logic                pixel_end;
  logic [7:0]          clipped;
  logic [7:0]          rep;
  logic [CfgDataW-1:0] remain_sub;
  logic [15:0]         p16;

  logic [1:0]          phase_q, phase_d;
  logic [23:0]         bytes_q, bytes_d;
  logic                is_run_q, is_run_d;
  logic [7:0]          left_q, left_d;
  logic [CfgDataW-1:0] remain_q, remain_d;

  always_comb begin
    if (cfg_i.pixel_bits == Bits24) begin
      depth = Depth24;
    end else if (cfg_i.pixel_bits == Bits32) begin
      depth = Depth32;
    end else if (cfg_i.pixel_bits == Bits16 && !cfg_i.rle_mode) begin
      depth = Depth16;
    end else begin
      depth = DepthBad;
    end
  end

  always_comb begin
    case (depth)
      Depth16: last_phase = 2'd1;
      Depth24: last_phase = 2'd2;
      default: last_phase = 2'd3;
    endcase
  end

  assign done      = (remain_q == '0);
  assign header    = cfg_i.rle_mode && (left_q == '0);
  assign pixel_end = (phase_q == last_phase);

  // clip a run to the pixels still missing from the image
  assign clipped = (remain_q[CfgDataW-1:8] == '0 && remain_q[7:0] < left_q) ?
                   remain_q[7:0] : left_q;
  assign rep        = (cfg_i.rle_mode && is_run_q) ? clipped : 8'd1;
  assign remain_sub = remain_q - {{(CfgDataW-8){1'b0}}, rep};
  assign p16        = {byte_i, bytes_q[7:0]};

  always_comb begin
    phase_d     = phase_q;
    bytes_d     = bytes_q;
    is_run_d    = is_run_q;
    left_d      = left_q;
    remain_d    = remain_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (clear_i) begin
      phase_d  = '0;
      bytes_d  = '0;
      is_run_d = 1'b0;
      left_d   = '0;
      remain_d = total_i;
    end else if (step_i) begin
      if (depth == DepthBad) begin
        res_valid_o  = 1'b1;
        res_o.status = StatusBadDepth;
      end else if (!done) begin
        if (header) begin
          is_run_d = byte_i[7];
          left_d   = byte_i[7] ? (byte_i - RunBias) : (byte_i + 8'd1);
          phase_d  = '0;
          bytes_d  = '0;
        end else if (!pixel_end) begin
          case (phase_q)
            2'd0:    bytes_d[7:0]   = byte_i;
            2'd1:    bytes_d[15:8]  = byte_i;
            default: bytes_d[23:16] = byte_i;
          endcase
          phase_d = phase_q + 2'd1;
        end else begin
          case (depth)
            Depth16: begin
              res_o.blue  = {p16[4:0], 3'b000};
              res_o.green = {p16[9:5], 3'b000};
              res_o.red   = {p16[14:10], 3'b000};
            end
            Depth24: begin
              res_o.blue  = bytes_q[7:0];
              res_o.green = bytes_q[15:8];
              res_o.red   = byte_i;
            end
            default: begin
              res_o.blue      = bytes_q[7:0];
              res_o.green     = bytes_q[15:8];
              res_o.red       = bytes_q[23:16];
              res_o.alpha     = byte_i;
              res_o.has_alpha = 1'b1;
            end
          endcase
          res_valid_o         = 1'b1;
          res_o.repeat_count  = rep;
          res_o.last_of_image = (remain_sub == '0);
          res_o.status        = StatusOk;
          remain_d            = remain_sub;
          phase_d             = '0;
          bytes_d             = '0;
          if (cfg_i.rle_mode) begin
            left_d = is_run_q ? 8'd0 : (left_q - 8'd1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= '0;
      bytes_q  <= '0;
      is_run_q <= 1'b0;
      left_q   <= '0;
      remain_q <= TotalReset;
    end else begin
      phase_q  <= phase_d;
      bytes_q  <= bytes_d;
      is_run_q <= is_run_d;
      left_q   <= left_d;
      remain_q <= remain_d;
    end
  end

`ifndef SYNTHESIS
  a_done_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && !clear_i && done && depth != DepthBad) |-> !res_valid_o)
    else $error("result produced after image complete");

  a_rep_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status == StatusOk) |-> (res_o.repeat_count != '0))
    else $error("pixel result with zero repeat count");

  a_remain_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !clear_i |=> (remain_q <= $past(remain_q)))
    else $error("remaining pixel count grew without a restart");

  a_last_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.last_of_image && !clear_i) |=> (remain_q == '0))
    else $error("last pixel flagged but pixels remain");
`endif

endmodule

FILE: hdl/tpsd_outbuf.sv
module tpsd_outbuf import tpsd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  tpsd_res_t in_res_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output tpsd_res_t out_res_o
);

  logic      valid_q, valid_d;
  tpsd_res_t res_q;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // hold the result until the downstream side takes it
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      res_q <= in_res_i;
    end
  end

endmodule

FILE: hdl/tga_pixel_stream_decoder.sv
// Channel   Handshake                    Payload
// input     in_valid_i / in_ready_o      data_byte_i
// result    out_valid_o / out_ready_i    red_o green_o blue_o alpha_o has_alpha_o
//                                        repeat_count_o last_of_image_o status_o
// config    cfg_valid_i / cfg_ready_o    cfg_index_i cfg_data_i
//
// One byte per cycle while the result register is not stalled; a result passes
// through the byte register and then the result register, and decode and the
// remaining-pixel subtract sit between them.
// Reset clears all control state and loads rle_mode 0, pixel_bits 24, pixel_total 1.
// A write to rle_mode, pixel_bits or pixel_total restarts decoding. A stalled result
// register stalls the byte register, and input backs up only when both are full.
module tga_pixel_stream_decoder import tpsd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          data_byte_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          red_o,
  output logic [7:0]          green_o,
  output logic [7:0]          blue_o,
  output logic [7:0]          alpha_o,
  output logic                has_alpha_o,
  output logic [7:0]          repeat_count_o,
  output logic                last_of_image_o,
  output logic                status_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  tpsd_cfg_t           cfg_q, cfg_d;
  logic [CfgDataW-1:0] total_q, total_d;
  logic                cfg_hit;
  logic [CfgDataW-1:0] total_load;

  logic       byte_valid_q, byte_valid_d;
  logic [7:0] byte_q;
  logic       advance;
  logic       res_valid;
  tpsd_res_t  res;
  logic       buf_ready;
  tpsd_res_t  out_res;

  assign cfg_ready_o = 1'b1;
  assign cfg_hit     = cfg_valid_i && (cfg_index_i == CfgRleMode ||
                       cfg_index_i == CfgPixelBits || cfg_index_i == CfgPixelTotal);
  assign total_load  = (cfg_index_i == CfgPixelTotal) ? cfg_data_i : total_q;

  always_comb begin
    cfg_d   = cfg_q;
    total_d = total_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgRleMode:    cfg_d.rle_mode   = cfg_data_i[0];
        CfgPixelBits:  cfg_d.pixel_bits = cfg_data_i[7:0];
        CfgPixelTotal: total_d          = cfg_data_i;
        default:       ;
      endcase
    end
  end

  // advance the byte register whenever the result register has room
  assign advance    = byte_valid_q && buf_ready;
  assign in_ready_o = !byte_valid_q || advance;

  always_comb begin
    byte_valid_d = byte_valid_q;
    if (in_ready_o) begin
      byte_valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rle_mode   <= 1'b0;
      cfg_q.pixel_bits <= BitsReset;
      total_q          <= TotalReset;
      byte_valid_q     <= 1'b0;
    end else begin
      cfg_q        <= cfg_d;
      total_q      <= total_d;
      byte_valid_q <= byte_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= data_byte_i;
    end
  end

  tpsd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .clear_i     (cfg_hit),
    .total_i     (total_load),
    .step_i      (advance),
    .byte_i      (byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  tpsd_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_ready_o  (buf_ready),
    .in_res_i    (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res)
  );

  assign red_o           = out_res.red;
  assign green_o         = out_res.green;
  assign blue_o          = out_res.blue;
  assign alpha_o         = out_res.alpha;
  assign has_alpha_o     = out_res.has_alpha;
  assign repeat_count_o  = out_res.repeat_count;
  assign last_of_image_o = out_res.last_of_image;
  assign status_o        = out_res.status;

endmodule

FILE: verif/tb_tga_pixel_stream_decoder.sv
`timescale 1ns / 1ps

module tb_tga_pixel_stream_decoder;
  import tpsd_pkg::*;

  localparam int unsigned TargetBytes = 1150;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned IdlePct     = 21;

  typedef struct {
    bit                  is_cfg;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
    logic [7:0]          byte_v;
    bit                  typed;
    bit                  typed_emits;
    tpsd_res_t           typed_res;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [7:0]          data_byte_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [7:0]          red_o;
  logic [7:0]          green_o;
  logic [7:0]          blue_o;
  logic [7:0]          alpha_o;
  logic                has_alpha_o;
  logic [7:0]          repeat_count_o;
  logic                last_of_image_o;
  logic                status_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  // shadow copy of the decoder registers and state
  logic        sh_rle   = 1'b0;
  logic [7:0]  sh_bits  = BitsReset;
  logic [31:0] sh_total = TotalReset;
  logic [2:0]  sh_phase = '0;
  logic [23:0] sh_bytes = '0;
  logic        sh_run   = 1'b0;
  logic [7:0]  sh_left  = '0;
  logic [31:0] sh_done  = '0;

  tpsd_res_t   pixel_q[$];
  stim_row_t   dir_tab[$];
  int          fail_cnt      = 0;
  int          useful_cnt    = 0;
  bit          steady        = 1'b0;
  bit          hold_off_req  = 1'b0;

  tga_pixel_stream_decoder DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .alpha_o        (alpha_o),
    .has_alpha_o    (has_alpha_o),
    .repeat_count_o (repeat_count_o),
    .last_of_image_o(last_of_image_o),
    .status_o       (status_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 0;
  end

  initial begin
    #(5_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Advance the shadow decoder by one byte and form the pixel it finishes.
  task automatic decode_byte(input logic [7:0] b, output bit emits, output bit ignored,
                             output tpsd_res_t res);
    int          nbytes;
    logic [31:0] rep;
    logic [31:0] remaining;
    logic [15:0] p;
    res     = '0;
    emits   = 1'b0;
    ignored = 1'b0;
    if (sh_bits == Bits24) begin
      nbytes = 3;
    end else if (sh_bits == Bits32) begin
      nbytes = 4;
    end else if (sh_bits == Bits16 && !sh_rle) begin
      nbytes = 2;
    end else begin
      res.status = StatusBadDepth;
      emits      = 1'b1;
      return;
    end
    if (sh_done >= sh_total) begin
      ignored = 1'b1;
      return;
    end
    // open a packet: literal of id+1 pixels or run of id-127 copies
    if (sh_rle && sh_left == 8'd0) begin
      if (b < 8'd128) begin
        sh_run  = 1'b0;
        sh_left = b + 8'd1;
      end else begin
        sh_run  = 1'b1;
        sh_left = b - RunBias;
      end
      sh_phase = '0;
      sh_bytes = '0;
      return;
    end
    if (int'(sh_phase) + 1 < nbytes) begin
      sh_bytes = sh_bytes | (24'(b) << (8 * sh_phase[1:0]));
      sh_phase = sh_phase + 3'd1;
      return;
    end
    case (nbytes)
      2: begin
        p         = {b, sh_bytes[7:0]};
        res.blue  = {p[4:0], 3'b000};
        res.green = {p[9:5], 3'b000};
        res.red   = {p[14:10], 3'b000};
      end
      3: begin
        res.blue  = sh_bytes[7:0];
        res.green = sh_bytes[15:8];
        res.red   = b;
      end
      default: begin
        res.blue      = sh_bytes[7:0];
        res.green     = sh_bytes[15:8];
        res.red       = sh_bytes[23:16];
        res.alpha     = b;
        res.has_alpha = 1'b1;
      end
    endcase
    sh_phase  = '0;
    sh_bytes  = '0;
    remaining = sh_total - sh_done;
    rep       = 32'd1;
    if (sh_rle) begin
      if (sh_run) begin
        // clip a run that overruns the image
        rep = 32'(sh_left);
        if (rep > remaining) rep = remaining;
        sh_left = '0;
      end else begin
        sh_left = sh_left - 8'd1;
      end
    end
    sh_done           = sh_done + rep;
    res.repeat_count  = rep[7:0];
    res.last_of_image = (sh_done == sh_total);
    res.status        = StatusOk;
    emits             = 1'b1;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    bit took;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pixel_q.size() != 0) @(posedge clk_i);
    // header bytes leave nothing to wait for, so let the pipe drain
    repeat (DrainCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do begin
      @(negedge clk_i);
      took = cfg_ready_o;
      @(posedge clk_i);
    end while (!took);
    cfg_valid_i <= 1'b0;
    case (idx)
      CfgRleMode:    sh_rle   = data[0];
      CfgPixelBits:  sh_bits  = data[7:0];
      CfgPixelTotal: sh_total = data;
      default:       return;
    endcase
    sh_phase = '0;
    sh_bytes = '0;
    sh_run   = 1'b0;
    sh_left  = '0;
    sh_done  = '0;
    @(posedge clk_i);
  endtask

  task automatic send_byte(input logic [7:0] b, input bit typed, input bit t_emits,
                           input tpsd_res_t t_res);
    bit        took;
    bit        emits;
    bit        ignored;
    tpsd_res_t res;
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    do begin
      @(negedge clk_i);
      took = in_ready_o;
      @(posedge clk_i);
    end while (!took);
    decode_byte(b, emits, ignored, res);
    if (!ignored) useful_cnt++;
    if (typed) begin
      if (t_emits) pixel_q.push_back(t_res);
    end else if (emits) begin
      pixel_q.push_back(res);
    end
    if (!steady) begin
      while ($urandom_range(99) < IdlePct) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
  endtask

  function automatic tpsd_res_t pixel_of(logic [7:0] r, logic [7:0] g, logic [7:0] bl,
                                         logic [7:0] a, logic ha, logic [7:0] rep,
                                         logic last, logic st);
    tpsd_res_t res;
    res.red           = r;
    res.green         = g;
    res.blue          = bl;
    res.alpha         = a;
    res.has_alpha     = ha;
    res.repeat_count  = rep;
    res.last_of_image = last;
    res.status        = st;
    return res;
  endfunction

  function automatic void add_cfg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    stim_row_t row;
    row.is_cfg      = 1'b1;
    row.idx         = idx;
    row.data        = data;
    row.byte_v      = '0;
    row.typed       = 1'b0;
    row.typed_emits = 1'b0;
    row.typed_res   = '0;
    dir_tab.push_back(row);
  endfunction

  function automatic void add_byte(logic [7:0] b, bit typed, bit t_emits, tpsd_res_t t_res);
    stim_row_t row;
    row.is_cfg      = 1'b0;
    row.idx         = '0;
    row.data        = '0;
    row.byte_v      = b;
    row.typed       = typed;
    row.typed_emits = t_emits;
    row.typed_res   = t_res;
    dir_tab.push_back(row);
  endfunction

  // One image: program the registers in random order, then stream its bytes.
  task automatic run_image(input bit force_long);
    logic        rle;
    logic [7:0]  bits;
    logic [31:0] total;
    logic [31:0] covered;
    logic [31:0] pix;
    int          nb;
    int          budget;
    int          sent;
    int          k;
    int          j;
    int          tmp;
    int          sel;
    int          order[3];
    bit          bad;
    rle = 1'($urandom_range(1));
    bad = ($urandom_range(99) < 12);
    if (bad) begin
      if (rle && $urandom_range(1)) begin
        bits = Bits16;
      end else begin
        do bits = 8'($urandom_range(255));
        while (bits == Bits16 || bits == Bits24 || bits == Bits32);
      end
    end else if (rle) begin
      bits = $urandom_range(1) ? Bits24 : Bits32;
    end else begin
      sel  = $urandom_range(2);
      bits = (sel == 0) ? Bits16 : (sel == 1) ? Bits24 : Bits32;
    end
    sel = $urandom_range(99);
    if (sel < 5)       total = 32'd0;
    else if (sel < 10) total = 32'hffff_ffff;
    else if (sel < 15) total = $urandom();
    else if (sel < 25) total = $urandom_range(100, 1000);
    else               total = $urandom_range(1, 40);
    if (force_long) begin
      rle   = 1'b0;
      bits  = Bits24;
      total = 32'd2000;
      bad   = 1'b0;
    end
    nb = (bits == Bits16) ? 2 : (bits == Bits24) ? 3 : 4;

    // a write to an unused index may go first; it restarts nothing, so it stays harmless
    if ($urandom_range(99) < 15) write_reg(CfgIdxW'($urandom_range(3, 255)), $urandom());
    order = '{0, 1, 2};
    for (j = 2; j > 0; j--) begin
      k        = $urandom_range(j);
      tmp      = order[j];
      order[j] = order[k];
      order[k] = tmp;
    end
    for (j = 0; j < 3; j++) begin
      case (order[j])
        0:       write_reg(CfgRleMode, ($urandom() & 32'hffff_fffe) | 32'(rle));
        1:       write_reg(CfgPixelBits, ($urandom() & 32'hffff_ff00) | 32'(bits));
        default: write_reg(CfgPixelTotal, total);
      endcase
    end

    if (force_long) hold_off_req = 1'b1;
    budget = force_long ? 400 : $urandom_range(30, 150);
    sent   = 0;
    if (bad) begin
      repeat ($urandom_range(4, 12)) send_byte(8'($urandom()), 1'b0, 1'b0, '0);
    end else if (!rle) begin
      for (pix = 0; pix < total && sent < budget; pix++) begin
        repeat (nb) begin
          send_byte(8'($urandom()), 1'b0, 1'b0, '0);
          sent++;
        end
      end
    end else begin
      covered = 0;
      while (covered < total && sent < budget) begin
        if ($urandom_range(1)) begin
          k = ($urandom_range(99) < 70) ? $urandom_range(1, 8) : $urandom_range(1, 128);
          send_byte(8'(k + 127), 1'b0, 1'b0, '0);
          repeat (nb) send_byte(8'($urandom()), 1'b0, 1'b0, '0);
          sent += nb + 1;
        end else begin
          k = ($urandom_range(99) < 80) ? $urandom_range(1, 4) : $urandom_range(1, 128);
          send_byte(8'(k - 1), 1'b0, 1'b0, '0);
          repeat (k * nb) send_byte(8'($urandom()), 1'b0, 1'b0, '0);
          sent += k * nb + 1;
        end
        covered += k;
      end
    end
    // trailing noise: partial pixels or bytes past the end of the image
    if (total == 0 || $urandom_range(99) < 10) begin
      repeat ($urandom_range(1, 5)) send_byte(8'($urandom()), 1'b0, 1'b0, '0);
    end
  endtask

  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_off_req = 1'b0;
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= steady || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  always @(negedge clk_i) begin : check_results
    tpsd_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pixel_q.size() == 0) begin
        $error("result with no pixel pending");
        fail_cnt++;
      end else begin
        want = pixel_q.pop_front();
        if (red_o !== want.red) begin
          $error("red: expected %0h, got %0h", want.red, red_o);
          fail_cnt++;
        end
        if (green_o !== want.green) begin
          $error("green: expected %0h, got %0h", want.green, green_o);
          fail_cnt++;
        end
        if (blue_o !== want.blue) begin
          $error("blue: expected %0h, got %0h", want.blue, blue_o);
          fail_cnt++;
        end
        if (alpha_o !== want.alpha) begin
          $error("alpha: expected %0h, got %0h", want.alpha, alpha_o);
          fail_cnt++;
        end
        if (has_alpha_o !== want.has_alpha) begin
          $error("has_alpha: expected %0h, got %0h", want.has_alpha, has_alpha_o);
          fail_cnt++;
        end
        if (repeat_count_o !== want.repeat_count) begin
          $error("repeat_count: expected %0d, got %0d", want.repeat_count, repeat_count_o);
          fail_cnt++;
        end
        if (last_of_image_o !== want.last_of_image) begin
          $error("last_of_image: expected %0h, got %0h", want.last_of_image, last_of_image_o);
          fail_cnt++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0h, got %0h", want.status, status_o);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    int phase;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    data_byte_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;

    // reset defaults: raw 24-bit, one pixel
    add_byte(8'h00, 1'b0, 1'b0, '0);
    add_byte(8'hff, 1'b0, 1'b0, '0);
    add_byte(8'h80, 1'b1, 1'b1, pixel_of(8'h80, 8'hff, 8'h00, 8'h00, 1'b0, 8'd1, 1'b1,
                                         StatusOk));
    add_byte(8'h12, 1'b1, 1'b0, '0);
    // raw 16-bit, field extremes
    add_cfg(CfgPixelBits, 32'(Bits16));
    add_cfg(CfgPixelTotal, 32'd3);
    add_byte(8'hff, 1'b0, 1'b0, '0);
    add_byte(8'hff, 1'b1, 1'b1, pixel_of(8'hf8, 8'hf8, 8'hf8, 8'h00, 1'b0, 8'd1, 1'b0,
                                         StatusOk));
    add_byte(8'h00, 1'b0, 1'b0, '0);
    add_byte(8'h00, 1'b1, 1'b1, pixel_of(8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'd1, 1'b0,
                                         StatusOk));
    add_byte(8'h5a, 1'b0, 1'b0, '0);
    add_byte(8'ha5, 1'b0, 1'b0, '0);
    // RLE 32-bit, longest run clipped to the image
    add_cfg(CfgRleMode, 32'd1);
    add_cfg(CfgPixelBits, 32'(Bits32));
    add_byte(8'hff, 1'b0, 1'b0, '0);
    add_byte(8'h01, 1'b0, 1'b0, '0);
    add_byte(8'h02, 1'b0, 1'b0, '0);
    add_byte(8'h03, 1'b0, 1'b0, '0);
    add_byte(8'h04, 1'b0, 1'b0, '0);
    add_byte(8'h99, 1'b1, 1'b0, '0);
    // unsupported depths, RLE at 16 bits among them
    add_cfg(CfgPixelBits, 32'(Bits16));
    add_byte(8'h00, 1'b1, 1'b1, pixel_of(8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'd0, 1'b0,
                                         StatusBadDepth));
    add_cfg(CfgPixelBits, 32'd0);
    add_byte(8'hff, 1'b1, 1'b1, pixel_of(8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'd0, 1'b0,
                                         StatusBadDepth));
    add_cfg(CfgPixelBits, 32'hff);
    add_byte(8'h55, 1'b1, 1'b1, pixel_of(8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'd0, 1'b0,
                                         StatusBadDepth));
    // empty image: bytes dropped
    add_cfg(CfgPixelBits, 32'(Bits24));
    add_cfg(CfgPixelTotal, 32'd0);
    add_byte(8'h10, 1'b1, 1'b0, '0);
    add_cfg(8'hff, 32'hffff_ffff);
    // RLE 24-bit: shortest run, then longest literal
    add_cfg(CfgPixelTotal, 32'd2);
    add_byte(8'h80, 1'b0, 1'b0, '0);
    add_byte(8'haa, 1'b0, 1'b0, '0);
    add_byte(8'hbb, 1'b0, 1'b0, '0);
    add_byte(8'hcc, 1'b0, 1'b0, '0);
    add_byte(8'h7f, 1'b0, 1'b0, '0);
    add_byte(8'h11, 1'b0, 1'b0, '0);
    add_byte(8'h22, 1'b0, 1'b0, '0);
    add_byte(8'h33, 1'b0, 1'b0, '0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        write_reg(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        send_byte(dir_tab[i].byte_v, dir_tab[i].typed, dir_tab[i].typed_emits,
                  dir_tab[i].typed_res);
      end
    end

    phase = 0;
    while (useful_cnt < TargetBytes) begin
      steady = (phase >= 6 && phase < 11);
      run_image(phase == 3);
      phase++;
    end
    steady = 1'b0;

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (4 * DrainCycles) @(posedge clk_i);
    if (fail_cnt == 0 && pixel_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: tga_pixel_stream_decoder.f
hdl/tpsd_pkg.sv
hdl/tpsd_core.sv
hdl/tpsd_outbuf.sv
hdl/tga_pixel_stream_decoder.sv
verif/tb_tga_pixel_stream_decoder.sv
